@@ src/i2c_register_access_master_assert.svh @@
// assertion macros used by the i2c register access master port checker
// no dependencies; include by bare file name
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// same-cycle implication, off while reset is held
`define I2CRM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("i2crm check failed");

// next-cycle implication, off while reset is held
`define I2CRM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("i2crm check failed");

// next-cycle implication that also covers reset itself
`define I2CRM_ASSERT_ALWAYS_NXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("i2crm check failed");

`endif

@@ src/i2crm_pkg.sv @@
// shared types, constants and decode functions of the i2c register access master
// no dependencies
`timescale 1ns / 1ps

package i2crm_pkg;

  // bus phases, one-hot
  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_START1    = 13'b0000000000010,
    PH_SEND_WR   = 13'b0000000000100,
    PH_ACK_A     = 13'b0000000001000,
    PH_SEND_REG  = 13'b0000000010000,
    PH_ACK_B     = 13'b0000000100000,
    PH_START2    = 13'b0000001000000,
    PH_SEND_RD   = 13'b0000010000000,
    PH_ACK_C     = 13'b0000100000000,
    PH_READ      = 13'b0001000000000,
    PH_SEND_DATA = 13'b0010000000000,
    PH_ACK_D     = 13'b0100000000000,
    PH_STOP      = 13'b1000000000000
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_START,
    K_SEND,
    K_ACK,
    K_READ,
    K_STOP
  } kind_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT  = 2'd2;

  localparam logic [6:0]  DEV_ADDR_RST   = 7'd81;
  localparam logic [15:0] UNIT_TICKS_RST = 16'd100;
  localparam logic [15:0] ACK_LIMIT_RST  = 16'd2000;

  // step counts and step positions inside a phase
  localparam logic [5:0] LEN_SEND  = 6'd34;
  localparam logic [5:0] LEN_READ  = 6'd17;
  localparam logic [5:0] LEN_SHORT = 6'd5;
  localparam logic [5:0] LEN_NONE  = 6'd0;
  localparam logic [5:0] SEND_TAIL = 6'd33;
  localparam logic [5:0] IDX_0     = 6'd0;
  localparam logic [5:0] IDX_1     = 6'd1;
  localparam logic [5:0] IDX_2     = 6'd2;
  localparam logic [5:0] IDX_3     = 6'd3;
  localparam logic [5:0] IDX_4     = 6'd4;
  localparam logic [5:0] ACK_POLL_IDX = IDX_2;
  localparam logic [5:0] ACK_LAST_IDX = IDX_4;
  localparam logic [5:0] STOP_LONG_IDX = IDX_3;
  localparam logic [5:0] STOP_LAST_IDX = IDX_4;
  localparam logic [2:0] UNITS_ONE  = 3'd1;
  localparam logic [2:0] UNITS_LONG = 3'd5;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] unit_ticks;
    logic [15:0] ack_limit;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic       op;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic       sda_in;
  } cmd_t;

  // lowest bit last, so the packed form matches the tdata layout
  typedef struct packed {
    logic       nack_seen;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  typedef struct packed {
    phase_t     phase;
    logic [5:0] idx;
    logic [7:0] shift;
    logic [7:0] recv;
    logic       nack;
    logic       scl;
    logic       sda;
    logic       done;
  } seq_st_t;

  function automatic kind_t kind_of(phase_t ph);
    kind_t k;
    unique case (ph)
      PH_START1, PH_START2:                          k = K_START;
      PH_SEND_WR, PH_SEND_REG, PH_SEND_RD,
      PH_SEND_DATA:                                  k = K_SEND;
      PH_ACK_A, PH_ACK_B, PH_ACK_C, PH_ACK_D:        k = K_ACK;
      PH_READ:                                       k = K_READ;
      PH_STOP:                                       k = K_STOP;
      default:                                       k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] len_of(kind_t k);
    logic [5:0] n;
    case (k)
      K_SEND:  n = LEN_SEND;
      K_READ:  n = LEN_READ;
      K_NONE:  n = LEN_NONE;
      default: n = LEN_SHORT;
    endcase
    return n;
  endfunction

  function automatic phase_t next_phase(phase_t ph, logic op);
    phase_t nx;
    unique case (ph)
      PH_START1:    nx = PH_SEND_WR;
      PH_SEND_WR:   nx = PH_ACK_A;
      PH_ACK_A:     nx = PH_SEND_REG;
      PH_SEND_REG:  nx = PH_ACK_B;
      PH_ACK_B:     nx = (op == OP_WRITE) ? PH_SEND_DATA : PH_START2;
      PH_START2:    nx = PH_SEND_RD;
      PH_SEND_RD:   nx = PH_ACK_C;
      PH_ACK_C:     nx = PH_READ;
      PH_READ:      nx = PH_STOP;
      PH_SEND_DATA: nx = PH_ACK_D;
      PH_ACK_D:     nx = PH_STOP;
      default:      nx = PH_IDLE;
    endcase
    return nx;
  endfunction

endpackage

@@ src/i2crm_seq.sv @@
// bus sequencer: phase/step state, delay and ack poll counters, pin drives
// depends on i2crm_pkg
`timescale 1ns / 1ps

module i2crm_seq #(
  parameter int unsigned CW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  i2crm_pkg::cmd_t  cmd,
  input  i2crm_pkg::cfg_t  cfg,
  output i2crm_pkg::res_t  res
);

  localparam int unsigned CMP_W = (CW > 16) ? CW : 16;

  i2crm_pkg::seq_st_t st_r, st_nxt;
  logic [CW-1:0] delay_r, delay_nxt;
  logic [CW-1:0] poll_r, poll_nxt;
  logic          held_op_r, held_op_nxt;
  logic [7:0]    held_reg_r, held_reg_nxt;
  logic [7:0]    held_data_r, held_data_nxt;

  // leave the current step; at the end of a phase load the next one
  function automatic i2crm_pkg::seq_st_t adv(i2crm_pkg::seq_st_t s, logic op,
                                              logic [6:0] dev, logic [7:0] hreg,
                                              logic [7:0] hdat);
    i2crm_pkg::seq_st_t r;
    i2crm_pkg::phase_t  nx;
    logic [5:0]         ni;
    r  = s;
    ni = s.idx + 6'd1;
    if (ni < i2crm_pkg::len_of(i2crm_pkg::kind_of(s.phase))) begin
      r.idx = ni;
    end else begin
      if (s.phase == i2crm_pkg::PH_READ) r.recv = s.shift;
      nx      = i2crm_pkg::next_phase(s.phase, op);
      r.phase = nx;
      r.idx   = i2crm_pkg::IDX_0;
      case (nx)
        i2crm_pkg::PH_IDLE:      r.done  = 1'b1;
        i2crm_pkg::PH_SEND_WR:   r.shift = {dev, 1'b0};
        i2crm_pkg::PH_SEND_RD:   r.shift = {dev, 1'b1};
        i2crm_pkg::PH_SEND_REG:  r.shift = hreg;
        i2crm_pkg::PH_SEND_DATA: r.shift = hdat;
        i2crm_pkg::PH_READ:      r.shift = 8'd0;
        default: ;
      endcase
    end
    return r;
  endfunction

  // pin changes and read sampling on entering a step
  function automatic i2crm_pkg::seq_st_t enter(i2crm_pkg::seq_st_t s, logic sda_in);
    i2crm_pkg::seq_st_t r;
    logic [5:0]         im1;
    r   = s;
    im1 = s.idx - 6'd1;
    case (i2crm_pkg::kind_of(s.phase))
      i2crm_pkg::K_START: begin
        case (s.idx)
          i2crm_pkg::IDX_0: r.scl = 1'b0;
          i2crm_pkg::IDX_1: r.sda = 1'b1;
          i2crm_pkg::IDX_2: r.scl = 1'b1;
          i2crm_pkg::IDX_3: r.sda = 1'b0;
          i2crm_pkg::IDX_4: r.scl = 1'b0;
          default: ;
        endcase
      end
      i2crm_pkg::K_SEND: begin
        if (s.idx == i2crm_pkg::IDX_0 || s.idx >= i2crm_pkg::SEND_TAIL) begin
          r.scl = 1'b0;
        end else begin
          // four steps per bit, msb first
          case (im1[1:0])
            2'd0:    r.scl = 1'b0;
            2'd1:    r.sda = 1'b0;
            2'd2:    r.sda = s.shift[~im1[4:2]];
            default: r.scl = 1'b1;
          endcase
        end
      end
      i2crm_pkg::K_ACK: begin
        case (s.idx)
          i2crm_pkg::IDX_0: begin
            r.scl = 1'b0;
            r.sda = 1'b1;
          end
          i2crm_pkg::IDX_1: r.scl = 1'b1;
          i2crm_pkg::IDX_4: r.scl = 1'b0;
          default: ;
        endcase
      end
      i2crm_pkg::K_READ: begin
        if (s.idx == i2crm_pkg::IDX_0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else if (s.idx[0]) begin
          r.scl = 1'b1;
        end else begin
          r.scl   = 1'b0;
          r.shift = {s.shift[6:0], sda_in};
        end
      end
      i2crm_pkg::K_STOP: begin
        case (s.idx)
          i2crm_pkg::IDX_0: r.sda = 1'b0;
          i2crm_pkg::IDX_1: r.scl = 1'b1;
          i2crm_pkg::IDX_2: r.sda = 1'b1;
          i2crm_pkg::IDX_3: r.scl = 1'b0;
          i2crm_pkg::IDX_4: r.scl = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  logic [15:0]    unit_eff;
  logic [CMP_W-1:0] delay_ext, unit_ext, poll_ext, limit_ext;
  logic [CW-1:0]  poll_inc;
  logic [2:0]     units;
  logic           is_ack, is_stop, is_poll, step;

  assign unit_eff  = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
  assign delay_ext = CMP_W'(delay_r);
  assign unit_ext  = CMP_W'(unit_eff);
  assign poll_ext  = CMP_W'(poll_r);
  assign limit_ext = CMP_W'(cfg.ack_limit);
  assign poll_inc  = (&poll_r) ? poll_r : poll_r + 1'b1;
  assign is_ack    = i2crm_pkg::kind_of(st_r.phase) == i2crm_pkg::K_ACK;
  assign is_stop   = st_r.phase == i2crm_pkg::PH_STOP;
  assign is_poll   = is_ack && st_r.idx == i2crm_pkg::ACK_POLL_IDX;
  assign units     = (is_stop && st_r.idx == i2crm_pkg::STOP_LONG_IDX) ?
                     i2crm_pkg::UNITS_LONG : i2crm_pkg::UNITS_ONE;

  always_comb begin
    st_nxt        = st_r;
    st_nxt.done   = 1'b0;
    delay_nxt     = delay_r;
    poll_nxt      = poll_r;
    held_op_nxt   = held_op_r;
    held_reg_nxt  = held_reg_r;
    held_data_nxt = held_data_r;
    step          = 1'b0;
    if (fire) begin
      if (st_r.phase == i2crm_pkg::PH_IDLE) begin
        if (cmd.start) begin
          held_op_nxt   = cmd.op;
          held_reg_nxt  = cmd.reg_addr;
          held_data_nxt = cmd.wdata;
          st_nxt.nack   = 1'b0;
          st_nxt.phase  = i2crm_pkg::PH_START1;
          st_nxt.idx    = i2crm_pkg::IDX_0;
          delay_nxt     = CW'(1);
          poll_nxt      = '0;
          st_nxt        = enter(st_nxt, cmd.sda_in);
        end
      end else if (is_poll) begin
        // ack taken on sda low or once the poll limit is reached
        if (!cmd.sda_in || poll_ext >= limit_ext) begin
          st_nxt.nack = st_nxt.nack | cmd.sda_in;
          step        = 1'b1;
        end else begin
          poll_nxt = poll_inc;
        end
      end else begin
        if (delay_ext >= unit_ext || (&delay_r)) begin
          if (poll_inc >= CW'(units)) begin
            step = 1'b1;
          end else begin
            delay_nxt = CW'(1);
            poll_nxt  = poll_inc;
          end
        end else begin
          delay_nxt = delay_r + 1'b1;
        end
      end

      if (step) begin
        delay_nxt = CW'(1);
        poll_nxt  = '0;
        st_nxt = adv(st_nxt, held_op_r, cfg.dev_addr, held_reg_r, held_data_r);
        st_nxt = enter(st_nxt, cmd.sda_in);
        if (i2crm_pkg::kind_of(st_nxt.phase) == i2crm_pkg::K_ACK &&
            st_nxt.idx == i2crm_pkg::ACK_POLL_IDX) begin
          // first poll happens on the tick the poll step is entered
          if (!cmd.sda_in || cfg.ack_limit == 16'd0) begin
            st_nxt.nack = st_nxt.nack | cmd.sda_in;
            st_nxt = adv(st_nxt, held_op_r, cfg.dev_addr, held_reg_r, held_data_r);
            st_nxt = enter(st_nxt, cmd.sda_in);
          end else begin
            // the entry tick already counts as one poll
            poll_nxt = CW'(1);
          end
        end else if ((i2crm_pkg::kind_of(st_nxt.phase) == i2crm_pkg::K_ACK &&
                      st_nxt.idx == i2crm_pkg::ACK_LAST_IDX) ||
                     (st_nxt.phase == i2crm_pkg::PH_STOP &&
                      st_nxt.idx == i2crm_pkg::STOP_LAST_IDX)) begin
          // zero-hold last step passes straight on
          st_nxt = adv(st_nxt, held_op_r, cfg.dev_addr, held_reg_r, held_data_r);
          st_nxt = enter(st_nxt, cmd.sda_in);
        end
        if (st_nxt.done) delay_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= i2crm_pkg::PH_IDLE;
      st_r.idx    <= '0;
      st_r.shift  <= '0;
      st_r.recv   <= '0;
      st_r.nack   <= 1'b0;
      st_r.scl    <= 1'b1;
      st_r.sda    <= 1'b1;
      st_r.done   <= 1'b0;
      delay_r     <= '0;
      poll_r      <= '0;
      held_op_r   <= 1'b0;
      held_reg_r  <= '0;
      held_data_r <= '0;
    end else begin
      st_r        <= st_nxt;
      delay_r     <= delay_nxt;
      poll_r      <= poll_nxt;
      held_op_r   <= held_op_nxt;
      held_reg_r  <= held_reg_nxt;
      held_data_r <= held_data_nxt;
    end
  end

  // result of this tick, taken from the updated state
  always_comb begin
    res.scl_level = st_nxt.scl;
    res.sda_level = st_nxt.sda;
    res.busy_res  = st_nxt.phase != i2crm_pkg::PH_IDLE;
    res.done_res  = st_nxt.done;
    res.read_data = st_nxt.recv;
    res.nack_seen = st_nxt.nack;
  end

endmodule

@@ src/i2crm_obuf.sv @@
// two-slot result buffer: output register plus skid slot
// depends on i2crm_pkg (result type)
`timescale 1ns / 1ps

module i2crm_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2crm_pkg::res_t push_data,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output i2crm_pkg::res_t out_data
);

  logic            valid_r, valid_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  i2crm_pkg::res_t data_r, data_nxt;
  i2crm_pkg::res_t skid_r, skid_nxt;

  assign push_ready = !skid_valid_r;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_comb begin
    valid_nxt      = valid_r;
    data_nxt       = data_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!valid_r || out_ready) begin
      // main slot frees up; the skid slot goes first
      if (skid_valid_r) begin
        valid_nxt      = 1'b1;
        data_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        valid_nxt = push;
        data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ src/i2c_register_access_master.sv @@
// i2c register access master, top level: streams, configuration registers
// depends on i2crm_pkg, i2crm_seq, i2crm_obuf
//
// Each input transfer is one tick of the bus timing. It carries the sampled
// SDA level and, while idle, an optional command: a single-register read
// (START, addr+w, reg, repeated START, addr+r, eight data bits, STOP) or a
// single-register write (START, addr+w, reg, data, STOP). Every input
// transfer gives exactly one output transfer with the SCL/SDA drive levels,
// busy, a one-tick done, the last read byte and the sticky nack flag.
// The result of an input transfer is registered before output valid; one item is
// taken per cycle, limited only by the output side. The tick work is done
// between the sequencer state registers and the output register.
// When the receiver stalls, one more result goes to a skid slot and
// in_tready then drops until the output drains. Configuration writes on
// cfg_* take effect at once and are meant for idle times.
// Reset (synchronous, rst_n low): bus idle with both lines released,
// configuration back to address 81, 100 ticks per unit, ack limit 2000.

`timescale 1ns / 1ps

module i2c_register_access_master #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_request[0], register_address[8:1], write_data[16:9], sda_in[17]
  input  logic [i2crm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // operation[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // scl_level[0], sda_level[1], busy_res[2], done_res[3], read_data[11:4],
  // nack_seen[12]
  output logic [i2crm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [i2crm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2crm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  i2crm_pkg::cfg_t cfg_r;
  i2crm_pkg::cmd_t cmd;
  i2crm_pkg::res_t res;
  i2crm_pkg::res_t out_res;
  logic            fire;
  logic            push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr   <= i2crm_pkg::DEV_ADDR_RST;
      cfg_r.unit_ticks <= i2crm_pkg::UNIT_TICKS_RST;
      cfg_r.ack_limit  <= i2crm_pkg::ACK_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        i2crm_pkg::CFG_DEV_ADDR:   cfg_r.dev_addr   <= cfg_wdata[6:0];
        i2crm_pkg::CFG_UNIT_TICKS: cfg_r.unit_ticks <= cfg_wdata;
        i2crm_pkg::CFG_ACK_LIMIT:  cfg_r.ack_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cmd.start    = in_tdata[0];
  assign cmd.op       = in_tuser;
  assign cmd.reg_addr = in_tdata[8:1];
  assign cmd.wdata    = in_tdata[16:9];
  assign cmd.sda_in   = in_tdata[17];

  assign in_tready = push_ready;
  assign fire      = in_tvalid && push_ready;

  i2crm_seq #(
    .CW (COUNTER_WIDTH)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cmd   (cmd),
    .cfg   (cfg_r),
    .res   (res)
  );

  i2crm_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = i2crm_pkg::OUT_TDATA_W'(out_res);

endmodule

@@ src/i2crm_checker.sv @@
// port-level checker for the i2c register access master, bound to the top level
// depends on i2crm_pkg and i2c_register_access_master_assert.svh
`timescale 1ns / 1ps
`include "i2c_register_access_master_assert.svh"

module i2crm_port_assert (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [i2crm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  i2crm_pkg::res_t r;

  assign r = out_tdata[i2crm_pkg::RES_W-1:0];

  // a stalled result must not move
  `I2CRM_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // the done tick reports the bus as free
  `I2CRM_ASSERT_IMP(a_done_not_busy, clk, rst_n, out_tvalid && r.done_res, !r.busy_res)
  // input only backs up when a result is waiting
  `I2CRM_ASSERT_IMP(a_ready_low_full, clk, rst_n, !in_tready, out_tvalid)
  // reset empties the result side
  `I2CRM_ASSERT_ALWAYS_NXT(a_reset_empty, clk, !rst_n, !out_tvalid && in_tready)

endmodule

bind i2c_register_access_master i2crm_port_assert u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/i2crm_checker.sv @@
// result checker for the i2c register access master: tracks the bus sequencer per input tick
// and compares every output transfer field by field; depends on i2crm_pkg
`timescale 1ns / 1ps

module i2crm_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [i2crm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [i2crm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [i2crm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2crm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                errors,
  output int                                pending,
  output logic                              access_open
);
  import i2crm_pkg::*;

  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  typedef enum logic [1:0] {ACT_NONE, ACT_POLL, ACT_SAMPLE} step_act_t;

  // what one pin step does on entry, and how many delay units it is held
  typedef struct packed {
    logic      set_scl;
    logic      scl_v;
    logic      set_sda;
    logic      sda_v;
    logic      data_bit;
    logic [2:0] units;
    step_act_t act;
  } pin_step_t;

  logic [6:0]  dev_addr;
  logic [15:0] unit_len;
  logic [15:0] ack_limit;

  phase_t      ph;
  logic [5:0]  step;
  logic [15:0] dcount;
  logic [15:0] pcount;
  logic [7:0]  shreg;
  logic [7:0]  held_reg;
  logic [7:0]  held_dat;
  logic [7:0]  rx_byte;
  logic        held_op;
  logic        nack;
  logic        scl_q;
  logic        sda_q;
  logic        done_q;

  res_t        bus_results_q[$];
  res_t        want;
  res_t        got;
  res_t        fresh;

  initial errors = 0;

  function automatic kind_t bus_kind(phase_t p);
    case (p)
      PH_START1, PH_START2:                                 return K_START;
      PH_SEND_WR, PH_SEND_REG, PH_SEND_RD, PH_SEND_DATA:    return K_SEND;
      PH_ACK_A, PH_ACK_B, PH_ACK_C, PH_ACK_D:               return K_ACK;
      PH_READ:                                              return K_READ;
      PH_STOP:                                              return K_STOP;
      default:                                              return K_NONE;
    endcase
  endfunction

  function automatic int unsigned steps_in(kind_t k);
    case (k)
      K_SEND:  return 34;
      K_READ:  return 17;
      K_NONE:  return 0;
      default: return 5;
    endcase
  endfunction

  function automatic phase_t phase_after(phase_t p, logic wr);
    case (p)
      PH_START1:    return PH_SEND_WR;
      PH_SEND_WR:   return PH_ACK_A;
      PH_ACK_A:     return PH_SEND_REG;
      PH_SEND_REG:  return PH_ACK_B;
      PH_ACK_B:     return (wr == OP_WRITE) ? PH_SEND_DATA : PH_START2;
      PH_START2:    return PH_SEND_RD;
      PH_SEND_RD:   return PH_ACK_C;
      PH_ACK_C:     return PH_READ;
      PH_READ:      return PH_STOP;
      PH_SEND_DATA: return PH_ACK_D;
      PH_ACK_D:     return PH_STOP;
      default:      return PH_IDLE;
    endcase
  endfunction

  function automatic pin_step_t plan_of(kind_t k, logic [5:0] idx);
    pin_step_t s;
    logic [1:0] r;
    s = '0;
    s.units = UNITS_ONE;
    s.act = ACT_NONE;
    r = idx[1:0] - 2'd1;
    case (k)
      K_START: begin
        case (idx)
          6'd0: begin s.set_scl = 1'b1; s.scl_v = 1'b0; end
          6'd1: begin s.set_sda = 1'b1; s.sda_v = 1'b1; end
          6'd2: begin s.set_scl = 1'b1; s.scl_v = 1'b1; end
          6'd3: begin s.set_sda = 1'b1; s.sda_v = 1'b0; end
          default: begin s.set_scl = 1'b1; s.scl_v = 1'b0; end
        endcase
      end
      K_SEND: begin
        if (idx == 6'd0 || idx >= 6'd33) begin
          s.set_scl = 1'b1; s.scl_v = 1'b0;
        end else begin
          // four steps per bit: clock low, data low, data bit, clock high
          case (r)
            2'd0: begin s.set_scl = 1'b1; s.scl_v = 1'b0; end
            2'd1: begin s.set_sda = 1'b1; s.sda_v = 1'b0; end
            2'd2: s.data_bit = 1'b1;
            default: begin s.set_scl = 1'b1; s.scl_v = 1'b1; end
          endcase
        end
      end
      K_ACK: begin
        case (idx)
          6'd0: begin
            s.set_scl = 1'b1; s.scl_v = 1'b0; s.set_sda = 1'b1; s.sda_v = 1'b1;
          end
          6'd1: begin s.set_scl = 1'b1; s.scl_v = 1'b1; end
          6'd2: begin s.units = 3'd0; s.act = ACT_POLL; end
          6'd3: ;
          default: begin s.set_scl = 1'b1; s.scl_v = 1'b0; s.units = 3'd0; end
        endcase
      end
      K_READ: begin
        if (idx == 6'd0) begin
          s.set_scl = 1'b1; s.scl_v = 1'b0; s.set_sda = 1'b1; s.sda_v = 1'b1;
        end else if (idx[0]) begin
          s.set_scl = 1'b1; s.scl_v = 1'b1;
        end else begin
          s.set_scl = 1'b1; s.scl_v = 1'b0; s.act = ACT_SAMPLE;
        end
      end
      K_STOP: begin
        case (idx)
          6'd0: begin s.set_sda = 1'b1; s.sda_v = 1'b0; end
          6'd1: begin s.set_scl = 1'b1; s.scl_v = 1'b1; end
          6'd2: begin s.set_sda = 1'b1; s.sda_v = 1'b1; end
          6'd3: begin s.set_scl = 1'b1; s.scl_v = 1'b0; s.units = UNITS_LONG; end
          default: begin s.set_scl = 1'b1; s.scl_v = 1'b1; s.units = 3'd0; end
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic load_phase(phase_t p);
    ph = p;
    step = '0;
    case (p)
      PH_SEND_WR:   shreg = {dev_addr, 1'b0};
      PH_SEND_RD:   shreg = {dev_addr, 1'b1};
      PH_SEND_REG:  shreg = held_reg;
      PH_SEND_DATA: shreg = held_dat;
      PH_READ:      shreg = '0;
      default: ;
    endcase
  endtask

  task automatic step_on();
    phase_t nx;
    dcount = 16'd1;
    pcount = '0;
    step = step + 6'd1;
    if (step < steps_in(bus_kind(ph))) return;
    if (ph == PH_READ) rx_byte = shreg;
    nx = phase_after(ph, held_op);
    if (nx == PH_IDLE) begin
      ph = PH_IDLE;
      step = '0;
      dcount = '0;
      done_q = 1'b1;
    end else begin
      load_phase(nx);
    end
  endtask

  // ack wait: taken on sda low or once the poll count reaches the limit
  function automatic bit ack_taken(logic sda);
    if (sda == 1'b0 || pcount >= ack_limit) begin
      nack = nack | sda;
      return 1'b1;
    end
    if (pcount < COUNT_TOP) pcount = pcount + 16'd1;
    return 1'b0;
  endfunction

  // enter the current step, passing straight through zero-length ones
  task automatic enter_steps(logic sda);
    kind_t k;
    pin_step_t s;
    logic [5:0] off;
    for (int g = 0; g < 16 && ph != PH_IDLE; g++) begin
      k = bus_kind(ph);
      if (k == K_NONE) begin
        ph = PH_IDLE;
        step = '0;
        return;
      end
      s = plan_of(k, step);
      if (s.act == ACT_POLL) begin
        if (ack_taken(sda)) begin
          step_on();
          continue;
        end
        return;
      end
      if (s.act == ACT_SAMPLE) shreg = {shreg[6:0], sda};
      if (s.set_scl) scl_q = s.scl_v;
      if (s.data_bit) begin
        off = step - 6'd1;
        sda_q = shreg[3'd7 - off[4:2]];
      end else if (s.set_sda) begin
        sda_q = s.sda_v;
      end
      if (s.units == 3'd0) begin
        step_on();
        continue;
      end
      return;
    end
  endtask

  task automatic bus_tick(logic start, logic op, logic [7:0] ra, logic [7:0] wd, logic sda,
                          output res_t r);
    kind_t k;
    pin_step_t s;
    logic [15:0] u;
    done_q = 1'b0;
    if (ph == PH_IDLE) begin
      if (start) begin
        held_op = op;
        held_reg = ra;
        held_dat = wd;
        nack = 1'b0;
        dcount = 16'd1;
        pcount = '0;
        load_phase(PH_START1);
        enter_steps(sda);
      end
    end else begin
      k = bus_kind(ph);
      s = plan_of(k, step);
      if (k == K_NONE) begin
        ph = PH_IDLE;
        step = '0;
      end else if (s.act == ACT_POLL) begin
        if (ack_taken(sda)) begin
          step_on();
          enter_steps(sda);
        end
      end else begin
        u = (unit_len == '0) ? 16'd1 : unit_len;
        if (dcount >= u || dcount == COUNT_TOP) begin
          // pcount doubles as the unit counter outside the ack wait
          if (pcount < COUNT_TOP) pcount = pcount + 16'd1;
          if (pcount >= s.units) begin
            step_on();
            enter_steps(sda);
          end else begin
            dcount = 16'd1;
          end
        end else begin
          dcount = dcount + 16'd1;
        end
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (ph != PH_IDLE);
    r.done_res  = done_q;
    r.read_data = rx_byte;
    r.nack_seen = nack;
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dev_addr  = DEV_ADDR_RST;
      unit_len  = UNIT_TICKS_RST;
      ack_limit = ACK_LIMIT_RST;
      ph        = PH_IDLE;
      step      = '0;
      dcount    = '0;
      pcount    = '0;
      shreg     = '0;
      held_op   = 1'b0;
      held_reg  = '0;
      held_dat  = '0;
      rx_byte   = '0;
      nack      = 1'b0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      done_q    = 1'b0;
      bus_results_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DEV_ADDR:   dev_addr = cfg_wdata[6:0];
          CFG_UNIT_TICKS: unit_len = cfg_wdata;
          CFG_ACK_LIMIT:  ack_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (bus_results_q.size() == 0) begin
          $error("output transfer with no expected result waiting");
          errors++;
        end else begin
          want = bus_results_q.pop_front();
          got = out_tdata[RES_W-1:0];
          check_field("scl_level", want.scl_level, got.scl_level);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("read_data", want.read_data, got.read_data);
          check_field("nack_seen", want.nack_seen, got.nack_seen);
        end
      end
      if (in_tvalid && in_tready) begin
        // tdata: start[0], register[8:1], write data[16:9], sda[17]
        bus_tick(in_tdata[0], in_tuser, in_tdata[8:1], in_tdata[16:9], in_tdata[17], fresh);
        bus_results_q.push_back(fresh);
      end
    end
    pending = bus_results_q.size();
    access_open = (ph != PH_IDLE);
  end

endmodule

@@ tb/sv/tb_i2c_register_access_master.sv @@
// testbench top for the i2c register access master: clock, reset, tick stimulus,
// configuration phases and the verdict; depends on i2crm_pkg and i2crm_checker
`timescale 1ns / 1ps

module tb_i2c_register_access_master;
  import i2crm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_LEN    = 80;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // start_request[0], register_address[8:1], write_data[16:9], sda_in[17]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // operation[0]
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // scl_level[0], sda_level[1], busy_res[2], done_res[3], read_data[11:4], nack_seen[12]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int   errors;
  int   pending;
  logic access_open;

  int gap_pct      = 0;
  int stall_pct    = 0;
  int sda_high_pct = 50;
  int start_pct    = 20;
  int hold_asked   = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  i2c_register_access_master DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  i2crm_checker CHK (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .pending     (pending),
    .access_open (access_open)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_tready <= 1'b0;
      hold_served <= hold_asked;
      hold_left <= HOLD_LEN - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic rand_sda();
    return ($urandom_range(99) < sda_high_pct);
  endfunction

  // one tick transfer; called and returning at a falling edge
  task automatic feed_tick(logic start, logic op, logic [7:0] ra, logic [7:0] wd, logic sda);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'b0, sda, wd, ra, start};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // one access from start to stop; busy_start offers commands the block must ignore
  task automatic run_access(logic op, logic [7:0] ra, logic [7:0] wd, logic busy_start);
    feed_tick(1'b1, op, ra, wd, rand_sda());
    while (access_open) feed_tick(busy_start, ~op, ~ra, ~wd, rand_sda());
  endtask

  // let the bus finish its access and all results drain before touching registers
  task automatic quiesce();
    while (access_open) feed_tick(1'b0, OP_READ, 8'h00, 8'h00, 1'b0);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_ticks(int n);
    for (int i = 0; i < n; i++) begin
      // sda bias changes in bursts so acks, nacks and read bits all vary
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       sda_high_pct = 10;
          1:       sda_high_pct = 50;
          default: sda_high_pct = 90;
        endcase
      end
      feed_tick($urandom_range(99) < start_pct, 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)), rand_sda());
    end
  endtask

  task automatic run_phase(logic [6:0] dev, logic [15:0] unit, logic [15:0] lim,
                           int gap, int stall, int n, bit long_hold);
    quiesce();
    set_reg(CFG_DEV_ADDR, {9'b0, dev});
    set_reg(CFG_UNIT_TICKS, unit);
    set_reg(CFG_ACK_LIMIT, lim);
    gap_pct = gap;
    stall_pct <= stall;
    if (long_hold) hold_asked <= hold_asked + 1;
    random_ticks(n);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: idle ticks, then a read that opens at the default address and timing
    repeat (3) feed_tick(1'b0, OP_WRITE, 8'hFF, 8'hFF, 1'b1);
    sda_high_pct = 10;
    feed_tick(1'b1, OP_READ, 8'h5A, 8'hC3, rand_sda());
    repeat (109) feed_tick(1'b0, OP_WRITE, 8'hA5, 8'h3C, rand_sda());
    // with the pipe empty, shorten the unit so the rest of the access runs fast
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    set_reg(CFG_UNIT_TICKS, 16'd1);
    while (access_open) feed_tick(1'b0, OP_READ, 8'h00, 8'h00, rand_sda());
    quiesce();

    // zero unit length behaves as one; zero ack limit takes the first poll as final
    set_reg(CFG_UNIT_TICKS, 16'd0);
    set_reg(CFG_DEV_ADDR, 16'd127);
    set_reg(CFG_ACK_LIMIT, 16'd0);
    sda_high_pct = 0;
    run_access(OP_WRITE, 8'hFF, 8'h00, 1'b0);
    sda_high_pct = 100;
    run_access(OP_READ, 8'h00, 8'h00, 1'b0);
    sda_high_pct = 50;
    run_access(OP_WRITE, 8'h00, 8'hFF, 1'b1);
    quiesce();

    set_reg(CFG_DEV_ADDR, 16'd0);
    set_reg(CFG_UNIT_TICKS, 16'd1);
    set_reg(CFG_ACK_LIMIT, 16'd4);
    sda_high_pct = 100;
    run_access(OP_WRITE, 8'hA5, 8'h5A, 1'b0);
    sda_high_pct = 0;
    run_access(OP_READ, 8'h81, 8'h00, 1'b0);

    run_phase(7'($urandom_range(127)), 16'd1, 16'd2000, 0, 0, 150, 1'b0);
    run_phase(7'd127, 16'd2, 16'd3, 48, 0, 150, 1'b0);
    run_phase(7'd0, 16'd1, 16'hFFFF, 0, 48, 150, 1'b1);
    run_phase(7'($urandom_range(127)), 16'd0, 16'd0, 20, 20, 150, 1'b0);
    // longest unit: only idle ticks, an access would never finish in time
    start_pct = 0;
    run_phase(7'($urandom_range(127)), 16'hFFFF, 16'd9, 0, 0, 40, 1'b0);
    start_pct = 20;
    run_phase(7'($urandom_range(127)), 16'd3, 16'd1, 0, 0, 120, 1'b1);

    quiesce();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
